// ----- src/plucked_string_synth_assert.svh -----
// Assertion shorthands shared by the RTL. Each expects clk and arst_n in scope.
`ifndef PLUCKED_STRING_SYNTH_ASSERT_SVH
`define PLUCKED_STRING_SYNTH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pss_pkg.sv -----
package pss_pkg;

	localparam int unsigned PERIOD_W   = 12;
	localparam int unsigned NOTE_W     = 24;
	localparam int unsigned DAMP_W     = 16;
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_LENGTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING       = 2'd2;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = 12'd441;
	localparam logic [NOTE_W-1:0]   NOTE_RST   = 24'd132300;
	localparam logic [DAMP_W-1:0]   DAMP_RST   = 16'd65274;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period_length;
		logic [NOTE_W-1:0]   note_length;
		logic [DAMP_W-1:0]   damping;
	} cfg_t;

	// Average of two samples scaled by an unsigned Q0.16 gain, truncated
	// toward zero and saturated to the sample range.
	function automatic sample_t damped_average(sample_t a, sample_t b, logic [DAMP_W-1:0] gain);
		logic signed [16:0] sum;
		logic signed [33:0] prod;
		logic signed [33:0] biased;
		logic signed [16:0] q;
		sample_t            res;
		sum    = {a[15], a} + {b[15], b};
		prod   = 34'(sum) * 34'($signed({1'b0, gain}));
		biased = prod + (prod[33] ? 34'sd131071 : 34'sd0);
		q      = biased[33:17];
		if (q[16] != q[15]) begin
			res = q[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			res = q[15:0];
		end
		return res;
	endfunction

endpackage

// ----- src/pss_in_if.sv -----
interface pss_in_if;
	logic                             valid;
	logic                             ready;
	logic                             restart;
	logic signed [pss_pkg::SAMPLE_W-1:0] noise;

	modport source(output valid, output restart, output noise, input ready);
	modport sink(input valid, input restart, input noise, output ready);
endinterface

// ----- src/pss_out_if.sv -----
interface pss_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [pss_pkg::SAMPLE_W-1:0] sample;
	logic                             last_of_note;
	logic                             note_done;

	modport source(output valid, output sample, output last_of_note, output note_done,
		input ready);
	modport sink(input valid, input sample, input last_of_note, input note_done,
		output ready);
endinterface

// ----- src/pss_cfg_if.sv -----
interface pss_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [pss_pkg::CFG_IDX_W-1:0]     index;
	logic [pss_pkg::CFG_DATA_W-1:0]    data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- src/plucked_string_synth.sv -----
// Plucked-string voice (delay-line feedback synthesis) in Q1.15. It takes one sample beat per
// clock while the output is not stalled and returns one result beat per input beat; each
// beat passes the s1 stage and then the output register, which lets the next beat enter
// while a result waits. The delay line is one memory of MAX_PERIOD 16-bit words with a
// single read and a single write per cycle: the read for a beat is issued as it is
// accepted, and a write to the same slot by the beat ahead is forwarded. The delay line
// is not cleared at reset; a note must fill it through its noise phase before it is read.
`include "plucked_string_synth_assert.svh"

module plucked_string_synth #(
	parameter int unsigned MAX_PERIOD = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	pss_in_if.sink     smp_in,
	pss_out_if.source  smp_out,
	pss_cfg_if.sink    cfg
);

	localparam int unsigned AW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
	localparam int unsigned CW = ((AW > pss_pkg::PERIOD_W) ? AW : pss_pkg::PERIOD_W) + 1;

	pss_pkg::cfg_t cfg_regs;

	pss_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	logic                       in_fire;
	logic                       adv;
	logic                       s1_valid_q;
	logic                       out_valid_q;
	logic                       restart_s1;
	pss_pkg::sample_t           noise_s1;
	logic [AW-1:0]              slot_s1;
	logic                       byp_s1;
	pss_pkg::sample_t           byp_data_s1;
	pss_pkg::sample_t           rdata_s1;
	logic [AW-1:0]              ptr_q;
	pss_pkg::sample_t           tap_q;
	logic [pss_pkg::NOTE_W-1:0] count_q;
	pss_pkg::sample_t           sample_q;
	logic                       last_q;
	logic                       done_q;

	logic [pss_pkg::NOTE_W-1:0] count_eff;
	logic [pss_pkg::NOTE_W-1:0] count_inc;
	pss_pkg::sample_t           tap_eff;
	pss_pkg::sample_t           tap_a;
	pss_pkg::sample_t           y;
	logic                       done;
	logic                       noise_phase;
	logic                       last;
	logic [CW-1:0]              ptr_plus;
	logic [AW-1:0]              ptr_adv;
	logic [AW-1:0]              ptr_nxt;
	logic [AW-1:0]              raddr;
	logic                       wen;

	pss_pkg::sample_t mem [MAX_PERIOD];

	assign adv          = s1_valid_q && (!out_valid_q || smp_out.ready);
	assign smp_in.ready = !s1_valid_q || adv;
	assign in_fire      = smp_in.valid && smp_in.ready;

	always_comb begin
		count_eff   = restart_s1 ? '0 : count_q;
		tap_eff     = restart_s1 ? '0 : tap_q;
		done        = count_eff >= cfg_regs.note_length;
		noise_phase = count_eff < pss_pkg::NOTE_W'(cfg_regs.period_length);
		tap_a       = byp_s1 ? byp_data_s1 : rdata_s1;
		y           = noise_phase ? noise_s1
			: pss_pkg::damped_average(tap_a, tap_eff, cfg_regs.damping);
		count_inc   = count_eff + pss_pkg::NOTE_W'(1);
		last        = !done && ((25'(count_eff) + 25'd1) == 25'(cfg_regs.note_length));
		ptr_plus    = CW'(slot_s1) + CW'(1);
		if ((ptr_plus >= CW'(cfg_regs.period_length)) || (ptr_plus >= CW'(MAX_PERIOD))) begin
			ptr_adv = '0;
		end else begin
			ptr_adv = ptr_plus[AW-1:0];
		end
		wen     = adv && !done;
		ptr_nxt = adv ? (done ? slot_s1 : ptr_adv) : ptr_q;
		raddr   = smp_in.restart ? '0 : ptr_nxt;
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[slot_s1] <= y;
		end
		if (in_fire) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			restart_s1  <= smp_in.restart;
			noise_s1    <= smp_in.noise;
			slot_s1     <= raddr;
			byp_s1      <= wen && (slot_s1 == raddr);
			byp_data_s1 <= y;
		end
		if (adv) begin
			sample_q <= done ? '0 : y;
			last_q   <= last;
			done_q   <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			ptr_q       <= '0;
			tap_q       <= '0;
			count_q     <= pss_pkg::NOTE_RST;
		end else begin
			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				ptr_q       <= ptr_nxt;
				count_q     <= done ? count_eff : count_inc;
				tap_q       <= (!done && !noise_phase) ? tap_a : tap_eff;
			end else if (smp_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign smp_out.valid        = out_valid_q;
	assign smp_out.sample       = sample_q;
	assign smp_out.last_of_note = last_q;
	assign smp_out.note_done    = done_q;

	`PSS_ASSERT_NXT(a_s1_hold, s1_valid_q && !adv, s1_valid_q && $stable(slot_s1), "stalled beat lost its slot")
	`PSS_ASSERT_NXT(a_bypass, in_fire && wen && (slot_s1 == raddr), byp_s1 && (byp_data_s1 == $past(y)), "same-slot write not forwarded")
	`PSS_ASSERT_NXT(a_state_idle, !adv, $stable(count_q) && $stable(ptr_q) && $stable(tap_q), "voice state moved without a beat")
	`PSS_ASSERT_IMP(a_done_silent, out_valid_q && done_q, (sample_q == '0) && !last_q, "ended note produced sound")

endmodule

// ----- src/pss_cfg_regs.sv -----
module pss_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	pss_cfg_if.sink       cfg,
	output pss_pkg::cfg_t regs
);

	pss_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.period_length <= pss_pkg::PERIOD_RST;
			regs_q.note_length   <= pss_pkg::NOTE_RST;
			regs_q.damping       <= pss_pkg::DAMP_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				pss_pkg::REG_PERIOD_LENGTH: begin
					regs_q.period_length <= cfg.data[pss_pkg::PERIOD_W-1:0];
				end
				pss_pkg::REG_NOTE_LENGTH: begin
					regs_q.note_length <= cfg.data[pss_pkg::NOTE_W-1:0];
				end
				pss_pkg::REG_DAMPING: begin
					regs_q.damping <= cfg.data[pss_pkg::DAMP_W-1:0];
				end
				default: begin
					regs_q <= regs_q;
				end
			endcase
		end
	end

endmodule
